FILE: rtl/rte_pkg.sv
// Shared types and constants for the RISC-V trap entry unit.
// Used by rte_decide and riscv_trap_entry_unit; depends on nothing else.
package rte_pkg;

  typedef logic [63:0] word_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_EXC_DELEG = 3'd0;
  localparam logic [2:0] REG_IRQ_DELEG = 3'd1;
  localparam logic [2:0] REG_IRQ_EN    = 3'd2;
  localparam logic [2:0] REG_MVEC      = 3'd3;
  localparam logic [2:0] REG_SVEC      = 3'd4;

  // Privilege levels.
  localparam logic [1:0] PRIV_U = 2'd0;
  localparam logic [1:0] PRIV_S = 2'd1;
  localparam logic [1:0] PRIV_M = 2'd3;

  // Item kinds.
  localparam logic KIND_EXC = 1'b0;
  localparam logic KIND_IRQ = 1'b1;

  // mstatus bit positions.
  localparam int unsigned BIT_SIE  = 1;
  localparam int unsigned BIT_MIE  = 3;
  localparam int unsigned BIT_SPIE = 5;
  localparam int unsigned BIT_MPIE = 7;
  localparam int unsigned BIT_SPP  = 8;
  localparam int unsigned BIT_MPP  = 11;

  // Standard interrupt lines and their priority, highest first.
  localparam logic [11:0] LINE_MASK = 12'hAAA;
  localparam int unsigned NUM_LINES = 6;
  localparam logic [3:0] LINE_ORDER [NUM_LINES] = '{
    4'd11, 4'd3, 4'd7, 4'd9, 4'd1, 4'd5
  };

  typedef struct packed {
    logic [31:0] exc_deleg;
    logic [11:0] irq_deleg;
    logic [11:0] irq_en;
    word_t       mvec;
    word_t       svec;
  } trap_cfg_t;

  typedef struct packed {
    logic        kind;
    logic [4:0]  exc_cause;
    word_t       fault_pc;
    word_t       fault_value;
    logic [11:0] pending_lines;
    logic [1:0]  cur_priv;
    word_t       status_in;
  } trap_req_t;

  typedef struct packed {
    logic       taken;
    logic       to_super;
    word_t      trap_cause;
    word_t      saved_pc;
    word_t      saved_value;
    word_t      status_out;
    logic [1:0] priv_out;
    word_t      handler_pc;
  } trap_rsp_t;

endpackage

FILE: rtl/rte_decide.sv
// Combinational trap decision: interrupt selection, delegation, mstatus
// stack push and handler pc. Depends on rte_pkg.
module rte_decide (
  input  rte_pkg::trap_req_t req,
  input  rte_pkg::trap_cfg_t cfg,
  output rte_pkg::trap_rsp_t rsp
);
  import rte_pkg::*;

  always_comb begin
    logic [11:0] act;
    logic [11:0] mp;
    logic [11:0] sp;
    logic [11:0] pick;
    logic [3:0]  line;
    logic        m_ok;
    logic        s_ok;
    logic        have;
    logic        sup;
    logic        deleg_bit;
    word_t       st;
    word_t       vec;
    word_t       base;

    act  = req.pending_lines & cfg.irq_en & LINE_MASK;
    mp   = act & ~cfg.irq_deleg;
    sp   = act & cfg.irq_deleg;
    m_ok = (req.cur_priv != PRIV_M) || req.status_in[BIT_MIE];
    s_ok = (req.cur_priv == PRIV_U) || ((req.cur_priv == PRIV_S) && req.status_in[BIT_SIE]);

    if (m_ok && (mp != 12'd0)) begin
      pick = mp;
    end else if (s_ok && (sp != 12'd0)) begin
      pick = sp;
    end else begin
      pick = 12'd0;
    end

    // Walk from lowest priority up so the highest pending line wins.
    line = 4'd0;
    for (int i = NUM_LINES - 1; i >= 0; i--) begin
      if (pick[LINE_ORDER[i]]) line = LINE_ORDER[i];
    end

    have      = (req.kind == KIND_EXC) || (pick != 12'd0);
    deleg_bit = (req.kind == KIND_IRQ) ? cfg.irq_deleg[line] : cfg.exc_deleg[req.exc_cause];
    sup       = ((req.cur_priv == PRIV_U) || (req.cur_priv == PRIV_S)) && deleg_bit;

    st = req.status_in;
    if (sup) begin
      st[BIT_SPIE] = req.status_in[BIT_SIE];
      st[BIT_SIE]  = 1'b0;
      st[BIT_SPP]  = req.cur_priv[0];
      vec          = cfg.svec;
    end else begin
      st[BIT_MPIE]            = req.status_in[BIT_MIE];
      st[BIT_MIE]             = 1'b0;
      st[BIT_MPP+1:BIT_MPP]   = req.cur_priv;
      vec                     = cfg.mvec;
    end
    base = {vec[63:2], 2'b00};

    if (!have) begin
      rsp.taken       = 1'b0;
      rsp.to_super    = 1'b0;
      rsp.trap_cause  = '0;
      rsp.saved_pc    = '0;
      rsp.saved_value = '0;
      rsp.status_out  = req.status_in;
      rsp.priv_out    = req.cur_priv;
      rsp.handler_pc  = req.fault_pc;
    end else begin
      rsp.taken    = 1'b1;
      rsp.to_super = sup;
      rsp.saved_pc = req.fault_pc;
      rsp.status_out = st;
      rsp.priv_out = sup ? PRIV_S : PRIV_M;
      if (req.kind == KIND_IRQ) begin
        rsp.trap_cause  = {1'b1, 59'd0, line};
        rsp.saved_value = '0;
        rsp.handler_pc  = vec[0] ? (base + {58'd0, line, 2'b00}) : base;
      end else begin
        rsp.trap_cause  = {59'd0, req.exc_cause};
        rsp.saved_value = req.fault_value;
        rsp.handler_pc  = base;
      end
    end
  end

endmodule

FILE: rtl/riscv_trap_entry_unit.sv
// Top level of the RISC-V trap entry unit: configuration registers, input
// register, decision logic and result register. Depends on rte_pkg, rte_decide.
//
//  channel  direction  handshake              payload
//  in       in         in_valid / in_ready    kind .. status_in
//  out      out        out_valid / out_ready  taken .. handler_pc
//  cfg      in         cfg_we                 cfg_index, cfg_data
//
// From input beat to result beat: the input register, then the result register
// after the trap decision logic. One beat per cycle sustained unless out_ready is
// low. Each stage holds while the stage after it is full and not drained, so a
// stalled output backs up at most two items. Synchronous reset clears the
// configuration registers and both valid flags.
module riscv_trap_entry_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  rte_pkg::word_t      cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                kind,
  input  logic [4:0]          exc_cause,
  input  rte_pkg::word_t      fault_pc,
  input  rte_pkg::word_t      fault_value,
  input  logic [11:0]         pending_lines,
  input  logic [1:0]          cur_priv,
  input  rte_pkg::word_t      status_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                taken,
  output logic                to_super,
  output rte_pkg::word_t      trap_cause,
  output rte_pkg::word_t      saved_pc,
  output rte_pkg::word_t      saved_value,
  output rte_pkg::word_t      status_out,
  output logic [1:0]          priv_out,
  output rte_pkg::word_t      handler_pc
);
  import rte_pkg::*;

  trap_cfg_t cfg;
  trap_req_t s1_req;
  logic      s1_valid;
  trap_rsp_t rsp_next;
  trap_rsp_t rsp;
  logic      s1_ready;
  logic      s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXC_DELEG: cfg.exc_deleg <= cfg_data[31:0];
        REG_IRQ_DELEG: cfg.irq_deleg <= cfg_data[11:0];
        REG_IRQ_EN:    cfg.irq_en    <= cfg_data[11:0];
        REG_MVEC:      cfg.mvec      <= cfg_data;
        REG_SVEC:      cfg.svec      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_req <= '{kind: kind, exc_cause: exc_cause, fault_pc: fault_pc,
                  fault_value: fault_value, pending_lines: pending_lines,
                  cur_priv: cur_priv, status_in: status_in};
    end
  end

  rte_decide u_decide (
    .req(s1_req),
    .cfg(cfg),
    .rsp(rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      rsp <= rsp_next;
    end
  end

  assign taken       = rsp.taken;
  assign to_super    = rsp.to_super;
  assign trap_cause  = rsp.trap_cause;
  assign saved_pc    = rsp.saved_pc;
  assign saved_value = rsp.saved_value;
  assign status_out  = rsp.status_out;
  assign priv_out    = rsp.priv_out;
  assign handler_pc  = rsp.handler_pc;

`ifndef SYNTHESIS
  // An accepted beat always lands in the input register.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted input beat did not reach the input register");

  // Both stages full and the output stalled: no new beat may be taken.
  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while the pipeline is full");

  // A staged item moves to the output when the output frees up.
  a_stage_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_ready |=> out_valid)
    else $error("staged item lost on the way to the output");

  // The new privilege follows the trap target.
  a_priv_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && taken |-> (priv_out == (to_super ? PRIV_S : PRIV_M)))
    else $error("new privilege does not match the trap target");

  // No trap means no cause and no S-mode write.
  a_no_trap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !taken |-> (trap_cause == '0) && !to_super)
    else $error("cause or target reported without a trap");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for riscv_trap_entry_unit: directed and random trap requests,
// with random gaps on both handshakes and results checked against a built-in predictor.
// Depends on rte_pkg and the riscv_trap_entry_unit RTL.
module testbench;
  import rte_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // Standard interrupt lines.
  localparam logic [4:0] LINE_SSI = 5'd1;
  localparam logic [4:0] LINE_MSI = 5'd3;
  localparam logic [4:0] LINE_STI = 5'd5;
  localparam logic [4:0] LINE_MTI = 5'd7;
  localparam logic [4:0] LINE_SEI = 5'd9;
  localparam logic [4:0] LINE_MEI = 5'd11;

  localparam word_t ST_SIE = word_t'(1) << BIT_SIE;
  localparam word_t ST_MIE = word_t'(1) << BIT_MIE;
  localparam logic [1:0] PRIV_RSVD = 2'd2;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_EXC_DELEG;
  word_t       cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = KIND_EXC;
  logic [4:0]  exc_cause = '0;
  word_t       fault_pc = '0;
  word_t       fault_value = '0;
  logic [11:0] pending_lines = '0;
  logic [1:0]  cur_priv = PRIV_U;
  word_t       status_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        taken;
  logic        to_super;
  word_t       trap_cause;
  word_t       saved_pc;
  word_t       saved_value;
  word_t       status_out;
  logic [1:0]  priv_out;
  word_t       handler_pc;

  trap_cfg_t   csr = '0;
  trap_rsp_t   pending_traps[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  bit          stall_enabled = 1'b1;

  riscv_trap_entry_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .exc_cause(exc_cause), .fault_pc(fault_pc), .fault_value(fault_value),
    .pending_lines(pending_lines), .cur_priv(cur_priv), .status_in(status_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .taken(taken), .to_super(to_super), .trap_cause(trap_cause), .saved_pc(saved_pc),
    .saved_value(saved_value), .status_out(status_out), .priv_out(priv_out),
    .handler_pc(handler_pc)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Trap decision for one request under the current CSR copy.
  function automatic trap_rsp_t trap_outcome(trap_req_t r);
    trap_rsp_t   o;
    logic [11:0] act;
    logic [11:0] pick;
    logic        m_ok;
    logic        s_ok;
    logic        is_irq;
    logic        sup;
    logic [4:0]  code;
    word_t       st;
    word_t       vec;
    word_t       base;
    o = '0;
    pick = '0;
    code = '0;
    is_irq = (r.kind == KIND_IRQ);
    if (!is_irq) begin
      code = r.exc_cause;
    end else begin
      act = r.pending_lines & csr.irq_en & LINE_MASK;
      m_ok = (r.cur_priv != PRIV_M) || r.status_in[BIT_MIE];
      s_ok = (r.cur_priv == PRIV_U) || (r.cur_priv == PRIV_S && r.status_in[BIT_SIE]);
      // Machine-level lines that are eligible always win over supervisor ones.
      if (m_ok && (act & ~csr.irq_deleg) != '0) begin
        pick = act & ~csr.irq_deleg;
      end else if (s_ok && (act & csr.irq_deleg) != '0) begin
        pick = act & csr.irq_deleg;
      end
      if (pick[LINE_MEI]) code = LINE_MEI;
      else if (pick[LINE_MSI]) code = LINE_MSI;
      else if (pick[LINE_MTI]) code = LINE_MTI;
      else if (pick[LINE_SEI]) code = LINE_SEI;
      else if (pick[LINE_SSI]) code = LINE_SSI;
      else if (pick[LINE_STI]) code = LINE_STI;
      if (pick == '0) begin
        o.status_out = r.status_in;
        o.priv_out = r.cur_priv;
        o.handler_pc = r.fault_pc;
        return o;
      end
    end
    sup = (r.cur_priv == PRIV_U || r.cur_priv == PRIV_S) &&
          (is_irq ? csr.irq_deleg[code] : csr.exc_deleg[code]);
    st = r.status_in;
    if (sup) begin
      st[BIT_SPIE] = st[BIT_SIE];
      st[BIT_SIE] = 1'b0;
      st[BIT_SPP] = r.cur_priv[0];
      vec = csr.svec;
      o.priv_out = PRIV_S;
    end else begin
      st[BIT_MPIE] = st[BIT_MIE];
      st[BIT_MIE] = 1'b0;
      st[BIT_MPP +: 2] = r.cur_priv;
      vec = csr.mvec;
      o.priv_out = PRIV_M;
    end
    base = {vec[63:2], 2'b00};
    o.taken = 1'b1;
    o.to_super = sup;
    o.trap_cause = {is_irq, 58'd0, code};
    o.saved_pc = r.fault_pc;
    o.saved_value = is_irq ? '0 : r.fault_value;
    o.status_out = st;
    o.handler_pc = (is_irq && vec[0]) ? base + {57'd0, code, 2'b00} : base;
    return o;
  endfunction

  function automatic trap_req_t make_req(logic k, logic [4:0] c, word_t pc, word_t tval,
                                         logic [11:0] pend, logic [1:0] priv, word_t st);
    trap_req_t r;
    r.kind = k;
    r.exc_cause = c;
    r.fault_pc = pc;
    r.fault_value = tval;
    r.pending_lines = pend;
    r.cur_priv = priv;
    r.status_in = st;
    return r;
  endfunction

  function automatic trap_req_t random_req();
    logic [11:0] pend;
    // Mostly random masks so several lines compete; some single lines.
    if ($urandom_range(99) < 70) pend = 12'($urandom);
    else pend = 12'd1 << (2 * $urandom_range(5) + 1);
    return make_req(1'($urandom), 5'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                    pend, 2'($urandom), {$urandom, $urandom});
  endfunction

  function automatic void check_field(string name, word_t want, word_t got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic issue_trap_request(trap_req_t r);
    while (stall_enabled && $urandom_range(99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= r.kind;
    exc_cause <= r.exc_cause;
    fault_pc <= r.fault_pc;
    fault_value <= r.fault_value;
    pending_lines <= r.pending_lines;
    cur_priv <= r.cur_priv;
    status_in <= r.status_in;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_traps.push_back(trap_outcome(r));
  endtask

  // Drops valid and holds off until every outstanding result beat has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_traps.size() != 0) @(posedge clk);
  endtask

  task automatic program_csrs(trap_cfg_t c);
    cfg_we <= 1'b1;
    cfg_index <= REG_EXC_DELEG;
    cfg_data <= word_t'(c.exc_deleg);
    @(posedge clk);
    cfg_index <= REG_IRQ_DELEG;
    cfg_data <= word_t'(c.irq_deleg);
    @(posedge clk);
    cfg_index <= REG_IRQ_EN;
    cfg_data <= word_t'(c.irq_en);
    @(posedge clk);
    cfg_index <= REG_MVEC;
    cfg_data <= c.mvec;
    @(posedge clk);
    cfg_index <= REG_SVEC;
    cfg_data <= c.svec;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    csr = c;
  endtask

  // Registers still hold their reset values here.
  task automatic test_reset_state();
    issue_trap_request(make_req(KIND_EXC, 5'd5, 64'h1000, 64'hdead, 12'h0, PRIV_U, '0));
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h2000, 64'h0, 12'hFFF, PRIV_U, ST_MIE));
    issue_trap_request(make_req(KIND_EXC, 5'd2, 64'h3000, 64'h4, 12'h0, PRIV_S, ST_SIE));
    wait_for_results();
  endtask

  task automatic test_directed();
    trap_cfg_t c;
    // Causes 0, 8 and 31 delegated; MTI delegated along with the S lines;
    // mtvec vectored near the top so the handler address wraps; stvec in mode 3.
    c.exc_deleg = 32'h8000_0101;
    c.irq_deleg = 12'h2A2;
    c.irq_en = 12'hFFF;
    c.mvec = 64'hFFFF_FFFF_FFFF_FFF1;
    c.svec = 64'h0000_0000_8000_0003;
    program_csrs(c);
    issue_trap_request(make_req(KIND_EXC, 5'd0, '1, '1, 12'hFFF, PRIV_U, '1));
    issue_trap_request(make_req(KIND_EXC, 5'd31, '0, '0, 12'h0, PRIV_S, '0));
    issue_trap_request(make_req(KIND_EXC, 5'd31, 64'h40, 64'h44, 12'h0, PRIV_M, '1));
    issue_trap_request(make_req(KIND_EXC, 5'd2, 64'h80, 64'h13, 12'h0, PRIV_U, ST_SIE));
    issue_trap_request(make_req(KIND_EXC, 5'd8, 64'h84, 64'h0, 12'h0, PRIV_RSVD, ST_MIE));
    // Polls that must not trap: nothing pending, or only non-standard bits.
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h100, 64'h55, 12'h000, PRIV_U, '1));
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h104, 64'h55, 12'h555, PRIV_U, '1));
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h108, 64'h0, 12'd1 << LINE_MEI,
                                PRIV_M, ST_MIE));
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h10c, 64'h0, 12'd1 << LINE_MEI,
                                PRIV_M, '0));
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h110, 64'h0, 12'hAAA, PRIV_U, '0));
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h114, 64'h0,
                                (12'd1 << LINE_MSI) | (12'd1 << LINE_SEI), PRIV_U, '0));
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h118, 64'h0, 12'd1 << LINE_MTI,
                                PRIV_U, '0));
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h11c, 64'h0, 12'd1 << LINE_MTI,
                                PRIV_S, ~ST_SIE));
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h120, 64'h0, 12'd1 << LINE_MTI,
                                PRIV_S, ST_SIE));
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h124, 64'h0,
                                (12'd1 << LINE_SEI) | (12'd1 << LINE_SSI) | (12'd1 << LINE_STI),
                                PRIV_U, '0));
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h128, 64'h0,
                                (12'd1 << LINE_SSI) | (12'd1 << LINE_STI), PRIV_U, '0));
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h12c, 64'h0, 12'd1 << LINE_STI,
                                PRIV_U, '0));
    // Reserved privilege is never S-eligible but counts as below M.
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h130, 64'h0, 12'd1 << LINE_SEI,
                                PRIV_RSVD, '1));
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h134, 64'h0, 12'd1 << LINE_MEI,
                                PRIV_RSVD, '0));
    issue_trap_request(make_req(KIND_IRQ, 5'd0, 64'h138, 64'h0, 12'd1 << LINE_SEI,
                                PRIV_M, '1));
    wait_for_results();
  endtask

  task automatic test_random_configs();
    trap_cfg_t c;
    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 0) begin
        c = '1;
      end else if (phase == 1) begin
        c = '0;
        c.irq_en = '1;
      end else begin
        c.exc_deleg = $urandom;
        c.irq_deleg = 12'($urandom);
        c.irq_en = 12'($urandom) | ($urandom_range(1) ? LINE_MASK : 12'h0);
        c.mvec = {$urandom, $urandom};
        c.svec = {$urandom, $urandom};
      end
      program_csrs(c);
      for (int n = 0; n < 45; n++) issue_trap_request(random_req());
      wait_for_results();
    end
  endtask

  task automatic test_back_to_back();
    trap_cfg_t c;
    c.exc_deleg = $urandom;
    c.irq_deleg = 12'($urandom);
    c.irq_en = LINE_MASK;
    c.mvec = {$urandom, $urandom};
    c.svec = {$urandom, $urandom};
    program_csrs(c);
    stall_enabled = 1'b0;
    for (int n = 0; n < 60; n++) issue_trap_request(random_req());
    wait_for_results();
    stall_enabled = 1'b1;
  endtask

  always @(posedge clk) begin
    out_ready <= !stall_enabled || ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_traps.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatches++;
      end else begin
        trap_rsp_t want;
        want = pending_traps.pop_front();
        check_field("taken", word_t'(want.taken), word_t'(taken));
        check_field("to_super", word_t'(want.to_super), word_t'(to_super));
        check_field("trap_cause", want.trap_cause, trap_cause);
        check_field("saved_pc", want.saved_pc, saved_pc);
        check_field("saved_value", want.saved_value, saved_value);
        check_field("status_out", want.status_out, status_out);
        check_field("priv_out", word_t'(want.priv_out), word_t'(priv_out));
        check_field("handler_pc", want.handler_pc, handler_pc);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_random_configs();
    test_back_to_back();
    wait_for_results();
    repeat (6) @(posedge clk);
    if (pending_traps.size() != 0) begin
      $error("%0d expected results never arrived", pending_traps.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
